// File: rtl/source_lexer_tokenizer_core_defines.svh
// Assertion macros shared by the scanner modules.
`ifndef SOURCE_LEXER_TOKENIZER_CORE_DEFINES_SVH
`define SOURCE_LEXER_TOKENIZER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SLT_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("%m failed");
`define SLT_ASSERT_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("%m failed");
`else
`define SLT_ASSERT(label, clk, rstn, prop)
`define SLT_ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

// File: rtl/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Types, codes and keyword table for the source lexer.
// ----------------------------------------------------------------------------
`default_nettype none
package slt_pkg;

  localparam int unsigned WordBufferLen = 8;
  localparam int unsigned IntBits       = 32;
  localparam int unsigned WlW           = $clog2(WordBufferLen + 2);
  localparam logic [IntBits-1:0] IntLimit = {1'b0, {(IntBits-1){1'b1}}};

  typedef enum logic [4:0] {
    K_LEX = 5'd0, K_ERR = 5'd1, K_EOF = 5'd2, K_EOL = 5'd3, K_ID = 5'd4,
    K_KW = 5'd5, K_INT = 5'd6, K_NUM = 5'd7, K_STR = 5'd8, K_ADD = 5'd9,
    K_SUB = 5'd10, K_MUL = 5'd11, K_DIV = 5'd12, K_IDIV = 5'd13, K_LT = 5'd14,
    K_LE = 5'd15, K_GT = 5'd16, K_GE = 5'd17, K_ASSIGN = 5'd18, K_NE = 5'd19,
    K_LEN = 5'd20, K_CONCAT = 5'd21, K_COLON = 5'd22, K_COMMA = 5'd23,
    K_LPAREN = 5'd24, K_RPAREN = 5'd25
  } kind_e;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  event_kind;
    logic [3:0]  keyword_index;
    logic [30:0] integer_value;
    logic        integer_overflow;
    logic [7:0]  lexeme_byte;
    logic        last_of_step;
  } out_item_t;

  // Front-end classification of one byte.
  typedef struct packed {
    logic       eof;
    logic [7:0] ch;
    logic       digit;
    logic       alpha;
    logic [3:0] dval;
  } cls_t;

  localparam int unsigned NumKw = 15;

  function automatic logic [3:0] kw_len(input logic [3:0] k);
    case (k)
      4'd0, 4'd5:                  return 4'd2;
      4'd2, 4'd8:                  return 4'd3;
      4'd1, 4'd13:                 return 4'd4;
      4'd7, 4'd14:                 return 4'd5;
      4'd4, 4'd9, 4'd11, 4'd12:    return 4'd6;
      4'd6, 4'd10:                 return 4'd7;
      default:                     return 4'd8;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input logic [3:0] k, input int unsigned i);
    logic [8*8-1:0] s;
    case (k)
      4'd0:    s = "do";
      4'd1:    s = "else";
      4'd2:    s = "end";
      4'd3:    s = "function";
      4'd4:    s = "global";
      4'd5:    s = "if";
      4'd6:    s = "integer";
      4'd7:    s = "local";
      4'd8:    s = "nil";
      4'd9:    s = "number";
      4'd10:   s = "require";
      4'd11:   s = "return";
      4'd12:   s = "string";
      4'd13:   s = "then";
      default: s = "while";
    endcase
    // literals are right-aligned; move the first character to the top byte
    s = s << (8 * (8 - int'(kw_len(k))));
    return s[8*(8-1-i) +: 8];
  endfunction

endpackage
`default_nettype wire

// File: rtl/source_lexer_tokenizer_core.sv
// Path: an item's results reach the result ports through the issue queue,
//   then one scanner step that writes the output queue.
// Throughput: one item per cycle; the scanner stalls while the 4-deep output
//   queue holds more than two results.
// Reset: rst_ni asynchronous, active low; both queues empty, scanner
//   in its start state, integer accumulator cleared.
// ----------------------------------------------------------------------------
// source_lexer_tokenizer_core
// Byte-stream lexical scanner: front classifies, back runs the DFA.
// ----------------------------------------------------------------------------
`default_nettype none
module source_lexer_tokenizer_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push,
  output logic                 full,
  input  slt_pkg::in_item_t    in_item_i,
  output logic                 empty,
  input  wire                  pop,
  output slt_pkg::out_item_t   out_item_o
);
  logic          q_valid, q_take;
  slt_pkg::cls_t q_cls;

  // Front: accept and classify, two-entry issue queue.
  slt_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .in_item_i,
    .q_valid_o(q_valid), .q_take_i(q_take), .q_cls_o(q_cls)
  );

  // Back: scanner step and result queue.
  slt_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_take_o(q_take), .q_cls_i(q_cls),
    .empty_o(empty), .pop_i(pop), .out_item_o
  );
endmodule
`default_nettype wire

// File: rtl/slt_front.sv
// ----------------------------------------------------------------------------
// slt_front
// Accepts input items, classifies the byte and pushes into the issue queue.
// ----------------------------------------------------------------------------
`default_nettype none
module slt_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  output logic                 full_o,
  input  slt_pkg::in_item_t    in_item_i,
  output logic                 q_valid_o,
  input  wire                  q_take_i,
  output slt_pkg::cls_t        q_cls_o
);
  `include "source_lexer_tokenizer_core_defines.svh"

  // Two-entry queue.
  slt_pkg::cls_t mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  slt_pkg::cls_t cls;
  logic          acc, take;

  always_comb begin
    cls.eof   = in_item_i.end_of_input;
    cls.ch    = in_item_i.source_byte;
    cls.digit = !cls.eof && cls.ch inside {["0":"9"]};
    cls.alpha = !cls.eof && (cls.ch inside {["a":"z"], ["A":"Z"]} || cls.ch == "_");
    cls.dval  = cls.ch[3:0];
  end

  assign full_o    = (cnt_q == 2'd2);
  assign acc       = push_i && !full_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign take      = q_take_i && q_valid_o;
  assign q_cls_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (acc) mem_q[wp_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (acc) wp_q <= ~wp_q;
      if (take) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, acc} - {1'b0, take};
    end
  end

  `SLT_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q != 2'd3)
  `SLT_ASSERT(a_no_ovf, clk_i, rst_ni, (cnt_q == 2'd2 && !take) |=> cnt_q == 2'd2)
  `SLT_ASSERT(a_ptr, clk_i, rst_ni, (cnt_q == 2'd0) |-> (wp_q == rp_q))
endmodule
`default_nettype wire

// File: rtl/slt_back.sv
// ----------------------------------------------------------------------------
// slt_back
// Scanner state machine: one byte per cycle while the output queue has room
// for two more results, up to two results into an output queue.
// ----------------------------------------------------------------------------
`default_nettype none
module slt_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  q_valid_i,
  output logic                 q_take_o,
  input  slt_pkg::cls_t        q_cls_i,
  output logic                 empty_o,
  input  wire                  pop_i,
  output slt_pkg::out_item_t   out_item_o
);
  `include "source_lexer_tokenizer_core_defines.svh"

  typedef enum logic [4:0] {
    S_START, S_EOL, S_INT, S_ID, S_GT, S_LT, S_DASH, S_SLASH, S_TILDE,
    S_DOT, S_STR, S_POINT, S_FRAC, S_EXP, S_EXPSIGN, S_EXPNUM, S_COMMENT,
    S_ESC, S_ESC0, S_ESC1, S_ESC2, S_ESC00, S_ESCD, S_ESC25
  } st_e;

  localparam int unsigned OqDepth = 4;
  localparam int unsigned IW = slt_pkg::IntBits;
  localparam int unsigned WL = slt_pkg::WordBufferLen;
  localparam int unsigned WLW = slt_pkg::WlW;

  st_e                 st_q, st_d;
  logic [7:0]          wc_q [WL];
  logic [WLW-1:0]      wl_q, wl_d;
  logic [IW-1:0]       acc_q, acc_d;
  logic                sat_q, sat_d;
  logic [7:0]          esc_q, esc_d;

  slt_pkg::out_item_t  oq_q [OqDepth];
  logic [1:0]          owp_q, orp_q;
  logic [2:0]          ocnt_q;

  slt_pkg::out_item_t  r0, r1;
  logic [1:0]          nres;
  logic                fire, wr_word;
  logic [WLW-1:0]      wr_idx;
  logic [3:0]          kw_hit_idx;
  logic                kw_hit;
  logic [IW-1:0]       acc_mul;
  logic                acc_ovf;

  assign q_take_o = q_valid_i && (ocnt_q <= 3'(OqDepth - 2));
  assign fire     = q_take_o;

  // Keyword match over the stored word.
  always_comb begin
    logic m;
    kw_hit = 1'b0; kw_hit_idx = '0;
    for (int k = slt_pkg::NumKw - 1; k >= 0; k--) begin
      m = (WLW'(slt_pkg::kw_len(4'(k))) == wl_q);
      for (int i = 0; i < 8; i++)
        if (i < int'(slt_pkg::kw_len(4'(k))) && wc_q[i] != slt_pkg::kw_char(4'(k), i))
          m = 1'b0;
      if (m) begin kw_hit = 1'b1; kw_hit_idx = 4'(k); end
    end
  end

  // Saturating accumulate of one digit.
  always_comb begin
    logic [IW+3:0] p;
    p = {4'd0, acc_q} * (IW + 4)'(10) + (IW + 4)'(q_cls_i.dval);
    acc_ovf = (p > (IW + 4)'(slt_pkg::IntLimit));
    acc_mul = acc_ovf ? slt_pkg::IntLimit : p[IW-1:0];
  end

  function automatic slt_pkg::out_item_t tok(input slt_pkg::kind_e k);
    slt_pkg::out_item_t o;
    o = '0; o.event_kind = k;
    return o;
  endfunction
  function automatic slt_pkg::out_item_t lex(input logic [7:0] b);
    slt_pkg::out_item_t o;
    o = '0; o.event_kind = slt_pkg::K_LEX; o.lexeme_byte = b;
    return o;
  endfunction

  always_comb begin
    logic [7:0] c;
    logic       e, dg, al, rescan;
    logic [7:0] ev;
    c = q_cls_i.ch; e = q_cls_i.eof; dg = q_cls_i.digit; al = q_cls_i.alpha;
    st_d = st_q; wl_d = wl_q; acc_d = acc_q; sat_d = sat_q; esc_d = esc_q;
    r0 = '0; r1 = '0; nres = 2'd0; rescan = 1'b0;
    wr_word = 1'b0; wr_idx = '0;
    ev = 8'd0;
    // first pass
    case (st_q)
      S_START: ;
      S_EOL: if (e || c != " ") begin r0 = tok(slt_pkg::K_EOL); nres = 2'd1; rescan = 1'b1; end
      S_INT: begin
        if (dg) begin acc_d = acc_mul; sat_d = sat_q | acc_ovf; r0 = lex(c); nres = 2'd1; end
        else if (!e && c == ".") begin r0 = lex(c); nres = 2'd1; st_d = S_POINT; end
        else if (!e && (c == "e" || c == "E")) begin r0 = lex(c); nres = 2'd1; st_d = S_EXP; end
        else begin
          r0 = tok(slt_pkg::K_INT); r0.integer_value = 31'(acc_q);
          r0.integer_overflow = sat_q; nres = 2'd1; rescan = 1'b1;
        end
      end
      S_ID: begin
        if (al || dg) begin
          if (wl_q < WLW'(WL)) begin wr_word = 1'b1; wr_idx = wl_q; end
          if (wl_q <= WLW'(WL)) wl_d = wl_q + 1'b1;
          r0 = lex(c); nres = 2'd1;
        end else begin
          if (kw_hit) begin r0 = tok(slt_pkg::K_KW); r0.keyword_index = kw_hit_idx; end
          else r0 = tok(slt_pkg::K_ID);
          nres = 2'd1; rescan = 1'b1;
        end
      end
      S_GT, S_LT: begin
        nres = 2'd1; st_d = S_START;
        if (!e && c == "=") r0 = tok(st_q == S_GT ? slt_pkg::K_GE : slt_pkg::K_LE);
        else begin r0 = tok(st_q == S_GT ? slt_pkg::K_GT : slt_pkg::K_LT); rescan = 1'b1; end
      end
      S_DASH: if (!e && c == "-") st_d = S_COMMENT;
              else begin r0 = tok(slt_pkg::K_SUB); nres = 2'd1; rescan = 1'b1; end
      S_SLASH: begin
        nres = 2'd1; st_d = S_START;
        if (!e && c == "/") r0 = tok(slt_pkg::K_IDIV);
        else begin r0 = tok(slt_pkg::K_DIV); rescan = 1'b1; end
      end
      S_TILDE, S_DOT: begin
        nres = 2'd1; st_d = S_START;
        if (!e && c == (st_q == S_TILDE ? "=" : "."))
          r0 = tok(st_q == S_TILDE ? slt_pkg::K_NE : slt_pkg::K_CONCAT);
        else begin r0 = tok(slt_pkg::K_ERR); rescan = e; end
      end
      S_STR: begin
        if (e || c < 8'd32) begin r0 = tok(slt_pkg::K_ERR); nres = 2'd1; st_d = S_START; rescan = e; end
        else if (c == "\"") begin r0 = tok(slt_pkg::K_STR); nres = 2'd1; st_d = S_START; end
        else if (c == "\\") st_d = S_ESC;
        else begin r0 = lex(c); nres = 2'd1; end
      end
      S_POINT, S_EXPSIGN: begin
        nres = 2'd1;
        if (!dg) begin r0 = tok(slt_pkg::K_ERR); st_d = S_START; rescan = e; end
        else begin r0 = lex(c); st_d = (st_q == S_POINT) ? S_FRAC : S_EXPNUM; end
      end
      S_FRAC, S_EXPNUM: begin
        nres = 2'd1;
        if (dg) r0 = lex(c);
        else if (st_q == S_FRAC && !e && (c == "e" || c == "E")) begin
          r0 = lex(c); st_d = S_EXP;
        end else begin r0 = tok(slt_pkg::K_NUM); rescan = 1'b1; end
      end
      S_EXP: begin
        nres = 2'd1;
        if (dg) begin r0 = lex(c); st_d = S_EXPNUM; end
        else if (!e && (c == "+" || c == "-")) begin r0 = lex(c); st_d = S_EXPSIGN; end
        else begin r0 = tok(slt_pkg::K_ERR); st_d = S_START; rescan = e; end
      end
      S_COMMENT: if (e || c == 8'h0a) rescan = 1'b1;
      default: begin
        // escape states
        logic ok, done;
        ok = 1'b0; done = 1'b0; ev = 8'd0;
        if (!e) begin
          case (st_q)
            S_ESC: begin
              case (c)
                "\"":    begin ok = 1'b1; done = 1'b1; ev = c; end
                "n":     begin ok = 1'b1; done = 1'b1; ev = 8'h0a; end
                "t":     begin ok = 1'b1; done = 1'b1; ev = 8'h09; end
                "\\":    begin ok = 1'b1; done = 1'b1; ev = c; end
                "0":     begin ok = 1'b1; esc_d = 8'd0; st_d = S_ESC0; end
                "1":     begin ok = 1'b1; esc_d = 8'd1; st_d = S_ESC1; end
                "2":     begin ok = 1'b1; esc_d = 8'd2; st_d = S_ESC2; end
                default: ok = 1'b0;
              endcase
            end
            S_ESC0: if (c == "0") begin ok = 1'b1; esc_d = 8'd0; st_d = S_ESC00; end
                    else if (dg) begin ok = 1'b1; esc_d = {4'd0, q_cls_i.dval}; st_d = S_ESCD; end
            S_ESC1: if (dg) begin ok = 1'b1; esc_d = 8'd10 + {4'd0, q_cls_i.dval}; st_d = S_ESCD; end
            S_ESC2: if (c inside {["0":"4"]}) begin
                      ok = 1'b1; esc_d = 8'd20 + {4'd0, q_cls_i.dval}; st_d = S_ESCD;
                    end else if (c == "5") begin ok = 1'b1; esc_d = 8'd25; st_d = S_ESC25; end
            S_ESC00: if (c inside {["1":"9"]}) begin ok = 1'b1; done = 1'b1; ev = {4'd0, q_cls_i.dval}; end
            S_ESCD: if (dg) begin
                      ok = 1'b1; done = 1'b1;
                      ev = 8'({esc_q, 3'b0} + {esc_q, 1'b0} + {4'd0, q_cls_i.dval});
                    end
            S_ESC25: if (c inside {["0":"5"]}) begin
                       ok = 1'b1; done = 1'b1; ev = 8'd250 + {4'd0, q_cls_i.dval};
                     end
            default: ok = 1'b0;
          endcase
        end
        if (!ok) begin r0 = tok(slt_pkg::K_ERR); nres = 2'd1; st_d = S_START; rescan = e; end
        else if (done) begin r0 = lex(ev); nres = 2'd1; st_d = S_STR; end
      end
    endcase
    // start-state pass: either fresh or rescan
    if (st_q == S_START || rescan) begin
      slt_pkg::out_item_t t;
      logic               has;
      t = '0; has = 1'b0; st_d = S_START;
      if (e) begin t = tok(slt_pkg::K_EOF); has = 1'b1; end
      else if (dg) begin
        acc_d = {{(IW-4){1'b0}}, q_cls_i.dval}; sat_d = 1'b0;
        t = lex(c); has = 1'b1; st_d = S_INT;
      end else if (al) begin
        wr_word = 1'b1; wr_idx = '0; wl_d = WLW'(1);
        t = lex(c); has = 1'b1; st_d = S_ID;
      end else begin
        case (c)
          " ":     ;
          8'h0a:   st_d = S_EOL;
          ">":     st_d = S_GT;
          "<":     st_d = S_LT;
          "-":     st_d = S_DASH;
          "/":     st_d = S_SLASH;
          "~":     st_d = S_TILDE;
          ".":     st_d = S_DOT;
          "\"":    st_d = S_STR;
          "+":     begin t = tok(slt_pkg::K_ADD); has = 1'b1; end
          "*":     begin t = tok(slt_pkg::K_MUL); has = 1'b1; end
          "=":     begin t = tok(slt_pkg::K_ASSIGN); has = 1'b1; end
          ":":     begin t = tok(slt_pkg::K_COLON); has = 1'b1; end
          ",":     begin t = tok(slt_pkg::K_COMMA); has = 1'b1; end
          "(":     begin t = tok(slt_pkg::K_LPAREN); has = 1'b1; end
          ")":     begin t = tok(slt_pkg::K_RPAREN); has = 1'b1; end
          "#":     begin t = tok(slt_pkg::K_LEN); has = 1'b1; end
          default: begin t = tok(slt_pkg::K_ERR); has = 1'b1; end
        endcase
      end
      if (has) begin
        if (nres == 2'd0) r0 = t; else r1 = t;
        nres = nres + 2'd1;
      end
    end
    if (nres == 2'd1) r0.last_of_step = 1'b1;
    if (nres == 2'd2) r1.last_of_step = 1'b1;
  end

  assign empty_o    = (ocnt_q == 3'd0);
  assign out_item_o = oq_q[orp_q];

  always_ff @(posedge clk_i) begin
    if (fire && wr_word) wc_q[wr_idx[$clog2(WL)-1:0]] <= q_cls_i.ch;
    if (fire && nres != 2'd0) oq_q[owp_q] <= r0;
    if (fire && nres == 2'd2) oq_q[owp_q + 2'd1] <= r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_START; wl_q <= '0; acc_q <= '0; sat_q <= 1'b0; esc_q <= '0;
      owp_q <= '0; orp_q <= '0; ocnt_q <= '0;
    end else begin
      if (fire) begin
        st_q <= st_d; wl_q <= wl_d; acc_q <= acc_d; sat_q <= sat_d; esc_q <= esc_d;
        owp_q <= owp_q + nres;
      end
      if (pop_i && !empty_o) orp_q <= orp_q + 2'd1;
      ocnt_q <= ocnt_q + (fire ? {1'b0, nres} : 3'd0) - {2'd0, pop_i && !empty_o};
    end
  end

  `SLT_ASSERT(a_oq_bound, clk_i, rst_ni, ocnt_q <= 3'(OqDepth))
  `SLT_ASSERT(a_wl_bound, clk_i, rst_ni, wl_q <= WLW'(WL + 1))
  `SLT_ASSERT(a_sat_lim, clk_i, rst_ni, sat_q |-> (acc_q == slt_pkg::IntLimit))
endmodule
`default_nettype wire

// File: tb/tb_source_lexer_tokenizer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_source_lexer_tokenizer_core
// Feeds source text byte by byte into the scanner and checks every event it
// produces against a behavioral scanner kept in this file.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_source_lexer_tokenizer_core;

  // Scanner states of the behavioral model.
  typedef enum int {
    ST_START, ST_EOL, ST_INT, ST_ID, ST_GT, ST_LT, ST_DASH, ST_SLASH, ST_TILDE,
    ST_DOT, ST_STR, ST_POINT, ST_FRAC, ST_EXP, ST_EXPSIGN, ST_EXPNUM,
    ST_COMMENT, ST_ESC, ST_ESC0, ST_ESC1, ST_ESC2, ST_ESC00, ST_ESCD, ST_ESC25
  } scan_st_e;

  localparam int unsigned EofCode   = 256;
  localparam int unsigned IdleLimit = 2000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  slt_pkg::in_item_t   in_item_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  slt_pkg::out_item_t  out_item_o;

  always #1 clk_i = ~clk_i;

  source_lexer_tokenizer_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  // Expected event stream and scoreboard counters.
  slt_pkg::out_item_t  events_due[$];
  int unsigned n_errors   = 0;
  int unsigned n_bytes    = 0;
  int unsigned n_events   = 0;
  int unsigned idle_count = 0;
  bit          src_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;

  // Behavioral scanner state.
  scan_st_e            sc_state = ST_START;
  logic [7:0]          sc_word [slt_pkg::WordBufferLen];
  int unsigned         sc_wlen = 0;
  logic [63:0]         sc_acc = '0;
  logic                sc_sat = 1'b0;
  int unsigned         sc_esc = 0;
  slt_pkg::out_item_t  step_ev [2];
  int unsigned         step_n;

  task automatic report(input string what, input slt_pkg::out_item_t got,
                        input slt_pkg::out_item_t want);
    n_errors++;
    $display("MISMATCH %s: got %p want %p", what, got, want);
  endtask

  function automatic void add_event(input slt_pkg::kind_e k, input logic [3:0] kw,
                                    input logic [30:0] iv, input logic ov,
                                    input logic [7:0] b);
    if (step_n < 2) begin
      step_ev[step_n] = '{event_kind: k, keyword_index: kw, integer_value: iv,
                          integer_overflow: ov, lexeme_byte: b, last_of_step: 1'b0};
      step_n++;
    end
  endfunction

  function automatic void lex_byte(input int unsigned b);
    add_event(slt_pkg::K_LEX, '0, '0, 1'b0, b[7:0]);
  endfunction

  function automatic void tok(input slt_pkg::kind_e k);
    add_event(k, '0, '0, 1'b0, 8'h00);
  endfunction

  function automatic bit is_dig(input int unsigned c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alp(input int unsigned c);
    return c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void accumulate(input int unsigned c);
    logic [63:0] d, lim;
    d   = c - "0";
    lim = (64'd1 << (slt_pkg::IntBits - 1)) - 1;
    if (sc_acc > (lim - d) / 10) begin
      sc_acc = lim;
      sc_sat = 1'b1;
    end else begin
      sc_acc = sc_acc * 10 + d;
    end
  endfunction

  // Keyword lookup over the collected word.
  function automatic void close_word();
    string kws [15];
    bit    hit;
    kws = '{"do", "else", "end", "function", "global", "if", "integer", "local",
            "nil", "number", "require", "return", "string", "then", "while"};
    for (int k = 0; k < 15; k++) begin
      if (sc_wlen == kws[k].len() && sc_wlen <= slt_pkg::WordBufferLen) begin
        hit = 1'b1;
        for (int i = 0; i < kws[k].len(); i++)
          if (sc_word[i] != kws[k][i]) hit = 1'b0;
        if (hit) begin
          add_event(slt_pkg::K_KW, 4'(k), '0, 1'b0, 8'h00);
          return;
        end
      end
    end
    tok(slt_pkg::K_ID);
  endfunction

  function automatic bit fail_to_start(input int unsigned c);
    tok(slt_pkg::K_ERR);
    sc_state = ST_START;
    return c == EofCode;
  endfunction

  function automatic void escape_done(input int unsigned v);
    lex_byte(v & 8'hFF);
    sc_state = ST_STR;
  endfunction

  // One scanner transition; returns 1 when the byte must be rescanned.
  function automatic bit scan(input int unsigned c);
    bit gt;
    case (sc_state)
      ST_START: begin
        if (c == EofCode) tok(slt_pkg::K_EOF);
        else if (c == " ") ;
        else if (c == 8'h0A) sc_state = ST_EOL;
        else if (is_dig(c)) begin
          sc_acc = '0; sc_sat = 1'b0; accumulate(c); lex_byte(c); sc_state = ST_INT;
        end else if (is_alp(c)) begin
          sc_word[0] = c[7:0]; sc_wlen = 1; lex_byte(c); sc_state = ST_ID;
        end
        else if (c == ">") sc_state = ST_GT;
        else if (c == "<") sc_state = ST_LT;
        else if (c == "-") sc_state = ST_DASH;
        else if (c == "/") sc_state = ST_SLASH;
        else if (c == "~") sc_state = ST_TILDE;
        else if (c == ".") sc_state = ST_DOT;
        else if (c == 8'h22) sc_state = ST_STR;
        else if (c == "+") tok(slt_pkg::K_ADD);
        else if (c == "*") tok(slt_pkg::K_MUL);
        else if (c == "=") tok(slt_pkg::K_ASSIGN);
        else if (c == ":") tok(slt_pkg::K_COLON);
        else if (c == ",") tok(slt_pkg::K_COMMA);
        else if (c == "(") tok(slt_pkg::K_LPAREN);
        else if (c == ")") tok(slt_pkg::K_RPAREN);
        else if (c == "#") tok(slt_pkg::K_LEN);
        else return fail_to_start(c);
        return 0;
      end
      ST_EOL: begin
        if (c == " ") return 0;
        tok(slt_pkg::K_EOL); sc_state = ST_START; return 1;
      end
      ST_INT: begin
        if (is_dig(c)) begin accumulate(c); lex_byte(c); end
        else if (c == ".") begin lex_byte(c); sc_state = ST_POINT; end
        else if (c == "e" || c == "E") begin lex_byte(c); sc_state = ST_EXP; end
        else begin
          add_event(slt_pkg::K_INT, '0, sc_acc[30:0], sc_sat, 8'h00);
          sc_state = ST_START; return 1;
        end
        return 0;
      end
      ST_ID: begin
        if (is_alp(c) || is_dig(c)) begin
          if (sc_wlen < slt_pkg::WordBufferLen) sc_word[sc_wlen] = c[7:0];
          if (sc_wlen <= slt_pkg::WordBufferLen) sc_wlen++;
          lex_byte(c); return 0;
        end
        close_word(); sc_state = ST_START; return 1;
      end
      ST_GT, ST_LT: begin
        gt = sc_state == ST_GT;
        sc_state = ST_START;
        if (c == "=") begin tok(gt ? slt_pkg::K_GE : slt_pkg::K_LE); return 0; end
        tok(gt ? slt_pkg::K_GT : slt_pkg::K_LT); return 1;
      end
      ST_DASH: begin
        if (c == "-") begin sc_state = ST_COMMENT; return 0; end
        tok(slt_pkg::K_SUB); sc_state = ST_START; return 1;
      end
      ST_SLASH: begin
        sc_state = ST_START;
        if (c == "/") begin tok(slt_pkg::K_IDIV); return 0; end
        tok(slt_pkg::K_DIV); return 1;
      end
      ST_TILDE: begin
        if (c != "=") return fail_to_start(c);
        tok(slt_pkg::K_NE); sc_state = ST_START; return 0;
      end
      ST_DOT: begin
        if (c != ".") return fail_to_start(c);
        tok(slt_pkg::K_CONCAT); sc_state = ST_START; return 0;
      end
      ST_STR: begin
        if (c == EofCode || c < 32) return fail_to_start(c);
        if (c == 8'h22) begin tok(slt_pkg::K_STR); sc_state = ST_START; end
        else if (c == 8'h5C) sc_state = ST_ESC;
        else lex_byte(c);
        return 0;
      end
      ST_POINT: begin
        if (!is_dig(c)) return fail_to_start(c);
        lex_byte(c); sc_state = ST_FRAC; return 0;
      end
      ST_FRAC, ST_EXPNUM: begin
        if (is_dig(c)) begin lex_byte(c); return 0; end
        if (sc_state == ST_FRAC && (c == "e" || c == "E")) begin
          lex_byte(c); sc_state = ST_EXP; return 0;
        end
        tok(slt_pkg::K_NUM); sc_state = ST_START; return 1;
      end
      ST_EXP: begin
        if (is_dig(c)) sc_state = ST_EXPNUM;
        else if (c == "+" || c == "-") sc_state = ST_EXPSIGN;
        else return fail_to_start(c);
        lex_byte(c); return 0;
      end
      ST_EXPSIGN: begin
        if (!is_dig(c)) return fail_to_start(c);
        lex_byte(c); sc_state = ST_EXPNUM; return 0;
      end
      ST_COMMENT: begin
        if (c == EofCode || c == 8'h0A) begin sc_state = ST_START; return 1; end
        return 0;
      end
      ST_ESC: begin
        if (c == 8'h22) escape_done(8'h22);
        else if (c == "n") escape_done(8'h0A);
        else if (c == "t") escape_done(8'h09);
        else if (c == 8'h5C) escape_done(8'h5C);
        else if (c == "0") begin sc_esc = 0; sc_state = ST_ESC0; end
        else if (c == "1") begin sc_esc = 1; sc_state = ST_ESC1; end
        else if (c == "2") begin sc_esc = 2; sc_state = ST_ESC2; end
        else return fail_to_start(c);
        return 0;
      end
      ST_ESC0: begin
        if (c == "0") begin sc_esc = 0; sc_state = ST_ESC00; end
        else if (is_dig(c)) begin sc_esc = c - "0"; sc_state = ST_ESCD; end
        else return fail_to_start(c);
        return 0;
      end
      ST_ESC1: begin
        if (!is_dig(c)) return fail_to_start(c);
        sc_esc = 10 + (c - "0"); sc_state = ST_ESCD; return 0;
      end
      ST_ESC2: begin
        if (c >= "0" && c <= "4") begin sc_esc = 20 + (c - "0"); sc_state = ST_ESCD; end
        else if (c == "5") begin sc_esc = 25; sc_state = ST_ESC25; end
        else return fail_to_start(c);
        return 0;
      end
      ST_ESC00: begin
        if (c < "1" || c > "9") return fail_to_start(c);
        escape_done(c - "0"); return 0;
      end
      ST_ESCD: begin
        if (!is_dig(c)) return fail_to_start(c);
        escape_done((sc_esc & 8'hFF) * 10 + (c - "0")); return 0;
      end
      ST_ESC25: begin
        if (c < "0" || c > "5") return fail_to_start(c);
        escape_done(250 + (c - "0")); return 0;
      end
      default: begin
        sc_state = ST_START; return 1;
      end
    endcase
  endfunction

  // Predict the events of one accepted item and queue them.
  function automatic void predict_events(input slt_pkg::in_item_t it);
    int unsigned c;
    c = it.end_of_input ? EofCode : it.source_byte;
    step_n = 0;
    if (scan(c)) begin
      sc_state = ST_START;
      void'(scan(c));
    end
    if (step_n > 0) step_ev[step_n-1].last_of_step = 1'b1;
    for (int i = 0; i < step_n; i++) events_due.push_back(step_ev[i]);
  endfunction

  // Send one item; holds push until the queue takes it. Push stays high
  // afterwards so that items can follow back to back.
  task automatic send_item(input logic [7:0] b, input logic eoi);
    if (src_idle_on && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= '{source_byte: b, end_of_input: eoi};
    do @(posedge clk_i); while (full);
    predict_events('{source_byte: b, end_of_input: eoi});
    n_bytes++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // Result side: random pop stalls, checks on the accepting edge.
  initial begin
    forever begin
      @(negedge clk_i);
      if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      n_events++;
      if (events_due.size() == 0) begin
        report("unexpected event", out_item_o, '0);
      end else begin
        slt_pkg::out_item_t want;
        want = events_due.pop_front();
        if (out_item_o.event_kind != want.event_kind)
          report("event_kind", out_item_o, want);
        if (out_item_o.keyword_index != want.keyword_index)
          report("keyword_index", out_item_o, want);
        if (out_item_o.integer_value != want.integer_value)
          report("integer_value", out_item_o, want);
        if (out_item_o.integer_overflow != want.integer_overflow)
          report("integer_overflow", out_item_o, want);
        if (out_item_o.lexeme_byte != want.lexeme_byte)
          report("lexeme_byte", out_item_o, want);
        if (out_item_o.last_of_step != want.last_of_step)
          report("last_of_step", out_item_o, want);
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Directed: every operator, EOL folding, comments, pushback cases.
  task automatic test_operators();
    send_text("+-*/ // <<=>>= = ~= # .. : , ( ) a-b --[ note\n  x\n");
    send_text("~x . 5/2 @");
    send_item(8'h00, 1'b1);
  endtask

  // Directed: numbers including saturation, fractions and exponents.
  task automatic test_numbers();
    send_text("0 2147483647 99999999999 1.5e+3 2e9 3.25E-1 7. 1e+ 8ex ");
    send_item(8'h00, 1'b1);
  endtask

  // Directed: keywords, long words, strings with every escape, bad escapes.
  task automatic test_words_strings();
    send_text("do else end function global if integer local nil number ");
    send_text("require return string then while functions abcdefghij _Z9 ");
    send_text({8'h22, "a\\", 8'h22, "\\n\\t\\\\\\001\\099\\100\\199\\255", 8'hFF, 8'h22});
    send_text({8'h22, "\\000", 8'h22, "\\256", 8'h22, "\\q", 8'h22, 8'h01});
    send_text({8'h22, "open"});
    send_item(8'hFF, 1'b1);
  endtask

  // Random: mostly well-formed fragments with random content, some noise.
  task automatic test_random(input int unsigned n_items);
    string       frags [12];
    int unsigned start;
    frags = '{"if", "while", "x_1", "123", "4.75e-2", "<=", "~=", "..",
              "-- c\n", "\n  ", "return", "//"};
    start = n_bytes;
    while (n_bytes - start < n_items) begin
      if (n_bytes - start > n_items * 3 / 4) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end
      if ($urandom_range(0, 60) == 0) send_item(8'($urandom_range(0, 255)), 1'b1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_text(frags[$urandom_range(0, 11)]);
        4: begin
          send_item(8'h22, 1'b0);
          repeat ($urandom_range(0, 5)) send_item(8'($urandom_range(32, 255)), 1'b0);
          if ($urandom_range(0, 1)) begin
            send_item(8'h5C, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b0);
            send_item(8'($urandom_range(48, 57)), 1'b0);
            send_item(8'($urandom_range(48, 57)), 1'b0);
          end
          send_item(8'h22, 1'b0);
        end
        5: repeat ($urandom_range(1, 12)) send_item(8'($urandom_range(48, 57)), 1'b0);
        6: send_item(8'($urandom_range(0, 255)), 1'b0);
        7: repeat ($urandom_range(1, 11)) send_item(8'($urandom_range(97, 122)), 1'b0);
        default: send_item(" ", 1'b0);
      endcase
    end
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_operators();
    test_numbers();
    test_words_strings();
    test_random(260);
    push <= 1'b0;
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Scanned %0d bytes, checked %0d events", n_bytes, n_events);
    $display("Covered operators, numbers, keywords, string escapes and errors");
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
